// ===== src/mvsm_pkg.sv =====
// mixer package: item kinds, field widths and the payload structs of both channels
// no dependencies
package mvsm_pkg;

    localparam int ADDR_W     = 14;
    localparam int SAMPLE_W   = 16;
    localparam int LEN_W      = 15;
    localparam int GAIN_W     = 16;
    localparam int MASK_W     = 8;
    localparam int FRAC_SHIFT = 12;
    localparam int MIN_DEPTH_LOG = 8;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    typedef struct packed {
        logic        [1:0]          kind;
        logic        [ADDR_W-1:0]   address;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic        [LEN_W-1:0]    sound_length;
        logic        [GAIN_W-1:0]   gain;
        logic                       looping;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_left;
        logic signed [SAMPLE_W-1:0] mixed_right;
        logic        [MASK_W-1:0]   active_voices;
        logic                       clipped;
    } t_out_item;

endpackage

// ===== src/mvsm_if.sv =====
// valid/ready channel interfaces for command items and mixed frames
// depends on mvsm_pkg
interface mvsm_in_if;
    import mvsm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mvsm_out_if;
    import mvsm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/multi_voice_sample_mixer_unit.sv =====
// stereo multi-voice pcm mixer: sample store, voice table and one shared multiplier
// depends on mvsm_pkg, mvsm_if and mvsm_ram
// write and start items are accepted, go through seven address reduction steps and are then applied
// a tick item checks every voice in turn; a sounding voice then passes the mull, mulr and accr states
// the single multiplier and the one store read port set the per-voice cost
// a finished frame waits in the output register while the next item is taken
// synchronous reset clears voice flags, slot pointer and output valid; the store is not cleared
module multi_voice_sample_mixer_unit #(
    parameter int VOICES       = 8,
    parameter int SAMPLE_DEPTH = 16384
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mvsm_in_if.sink          i_in,
    mvsm_out_if.source       o_out
);
    import mvsm_pkg::*;

    localparam int SAW    = $clog2(SAMPLE_DEPTH);
    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ACC_W  = 32 + $clog2(VOICES + 1);
    localparam int RED_K  = ADDR_W - MIN_DEPTH_LOG;
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

    typedef enum logic [2:0] {
        S_IDLE, S_RED, S_APPLY, S_VCHK, S_MULL, S_MULR, S_ACCR, S_FIN
    } t_state;

    t_state                    r_state;
    t_in_item                  r_item;
    logic [ADDR_W-1:0]         r_red;
    logic [2:0]                r_step;
    logic [VW-1:0]             r_voice;
    logic [VW-1:0]             r_slot;
    logic [SAW-1:0]            r_raddr;
    logic signed [31:0]        r_prod;
    logic signed [ACC_W-1:0]   r_acc_l;
    logic signed [ACC_W-1:0]   r_acc_r;
    logic [MASK_W-1:0]         r_mask;
    logic                      r_ovalid;
    t_out_item                 r_out;

    logic [SAW-1:0]            r_base [VOICES];
    logic [SAW-1:0]            r_rd   [VOICES];
    logic [LEN_W-1:0]          r_len  [VOICES];
    logic [LEN_W-1:0]          r_pos  [VOICES];
    logic [GAIN_W-1:0]         r_gain [VOICES];
    logic [VOICES-1:0]         r_act;
    logic [VOICES-1:0]         r_loop;

    logic [31:0]               w_lim;
    logic                      w_cur_act;
    logic                      w_end;
    logic                      w_stop;
    logic                      w_wrap;
    logic [SAW-1:0]            w_eff;
    logic [SAW-1:0]            n_rd;
    logic [LEN_W-1:0]          n_pos;
    logic                      w_last;
    logic [31:0]               w_rdata;
    logic signed [15:0]        w_mul_s;
    logic signed [32:0]        w_prod;
    logic signed [ACC_W-1:0]   w_sl;
    logic signed [ACC_W-1:0]   w_sr;
    logic                      w_clip_l;
    logic                      w_clip_r;
    logic                      w_out_free;
    logic                      w_we;

    assign w_lim     = 32'(SAMPLE_DEPTH) << r_step;
    assign w_cur_act = r_act[r_voice];
    assign w_end     = r_pos[r_voice] >= r_len[r_voice];
    assign w_stop    = w_end && (!r_loop[r_voice] || r_len[r_voice] == '0);
    assign w_wrap    = w_end && !w_stop;
    assign w_eff     = w_wrap ? r_base[r_voice] : r_rd[r_voice];
    assign n_rd      = (w_eff == SAW'(SAMPLE_DEPTH - 1)) ? '0 : w_eff + 1'b1;
    assign n_pos     = (w_wrap ? '0 : r_pos[r_voice]) + 1'b1;
    assign w_last    = r_voice == VW'(VOICES - 1);

    assign w_mul_s   = (r_state == S_MULL) ? $signed(w_rdata[31:16]) : $signed(w_rdata[15:0]);
    assign w_prod    = w_mul_s * $signed({1'b0, r_gain[r_voice]});

    assign w_sl      = r_acc_l >>> FRAC_SHIFT;
    assign w_sr      = r_acc_r >>> FRAC_SHIFT;
    assign w_clip_l  = (w_sl > SAT_MAX) || (w_sl < SAT_MIN);
    assign w_clip_r  = (w_sr > SAT_MAX) || (w_sr < SAT_MIN);
    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_we      = (r_state == S_APPLY) && (r_item.kind == KIND_WRITE);

    mvsm_ram #(
        .WIDTH (32),
        .DEPTH (SAMPLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (SAW'(r_red)),
        .i_wdata ({r_item.left_sample, r_item.right_sample}),
        .i_raddr ((r_state == S_VCHK) ? w_eff : r_raddr),
        .o_rdata (w_rdata)
    );

    assign i_in.ready    = r_state == S_IDLE;
    assign o_out.valid   = r_ovalid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_act    <= '0;
            r_slot   <= '0;
            r_ovalid <= 1'b0;
            r_voice  <= '0;
        end else begin
            if (o_out.ready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_item  <= i_in.payload;
                        r_red   <= i_in.payload.address;
                        r_step  <= 3'(RED_K);
                        r_voice <= '0;
                        r_acc_l <= '0;
                        r_acc_r <= '0;
                        r_mask  <= '0;
                        case (i_in.payload.kind)
                            KIND_WRITE: r_state <= S_RED;
                            KIND_START: r_state <= S_RED;
                            KIND_TICK:  r_state <= S_VCHK;
                            default:    r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RED: begin
                    if (32'(r_red) >= w_lim) begin
                        r_red <= r_red - w_lim[ADDR_W-1:0];
                    end
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (r_item.kind == KIND_START) begin
                        r_base[r_slot] <= SAW'(r_red);
                        r_rd[r_slot]   <= SAW'(r_red);
                        r_len[r_slot]  <= r_item.sound_length;
                        r_pos[r_slot]  <= '0;
                        r_gain[r_slot] <= r_item.gain;
                        r_loop[r_slot] <= r_item.looping;
                        r_act[r_slot]  <= 1'b1;
                        r_slot <= (r_slot == VW'(VOICES - 1)) ? '0 : r_slot + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_VCHK: begin
                    if (w_cur_act && !w_stop) begin
                        r_pos[r_voice]  <= n_pos;
                        r_rd[r_voice]   <= n_rd;
                        r_raddr         <= w_eff;
                        r_mask[r_voice] <= 1'b1;
                        r_state         <= S_MULL;
                    end else begin
                        if (w_cur_act) begin
                            r_act[r_voice] <= 1'b0;
                        end
                        if (w_last) begin
                            r_state <= S_FIN;
                        end else begin
                            r_voice <= r_voice + 1'b1;
                        end
                    end
                end
                S_MULL: begin
                    r_prod  <= w_prod[31:0];
                    r_state <= S_MULR;
                end
                S_MULR: begin
                    r_acc_l <= r_acc_l + ACC_W'(r_prod);
                    r_prod  <= w_prod[31:0];
                    r_state <= S_ACCR;
                end
                S_ACCR: begin
                    r_acc_r <= r_acc_r + ACC_W'(r_prod);
                    if (w_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_voice <= r_voice + 1'b1;
                        r_state <= S_VCHK;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out.mixed_left    <= (w_sl > SAT_MAX) ? 16'sh7fff :
                                               (w_sl < SAT_MIN) ? 16'sh8000 : w_sl[15:0];
                        r_out.mixed_right   <= (w_sr > SAT_MAX) ? 16'sh7fff :
                                               (w_sr < SAT_MIN) ? 16'sh8000 : w_sr[15:0];
                        r_out.active_voices <= r_mask;
                        r_out.clipped       <= w_clip_l || w_clip_r;
                        r_ovalid            <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_red_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> (32'(r_red) < SAMPLE_DEPTH))
        else $error("reduced address not below store depth");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VCHK && w_cur_act) |-> (32'(w_eff) < SAMPLE_DEPTH))
        else $error("voice read address outside store");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VCHK && w_cur_act) |-> (r_pos[r_voice] <= r_len[r_voice]))
        else $error("voice position ran past its length");

    a_mask_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> ((r_mask & ~MASK_W'(r_act)) == '0))
        else $error("mixed voice reported but not active");

endmodule

// ===== src/mvsm_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module mvsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
